FILE: rtl/atg_pkg.sv
// Package for the additive tone generator: widths, register map, the quarter-wave
// sine table and the per-harmonic weight and reciprocal tables.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package atg_pkg;

  // Block dimensions.
  localparam int MAX_TERMS  = 16;
  localparam int TABLE_BITS = 12;
  localparam int PHASE_BITS = 32;

  // Register map (index of each register on the configuration port).
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAVE_SHAPE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 2'd3;

  localparam int STEP_W  = 32;
  localparam int AMP_W   = 15;
  localparam int SHAPE_W = 2;
  localparam int COUNT_W = 5;

  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;

  // Sine table: quarter wave of 2^(TABLE_BITS-2)+1 entries in unsigned Q0.15.
  localparam int QLEN    = 1 << (TABLE_BITS - 2);
  localparam int QA_W    = TABLE_BITS - 1;
  localparam int QW_W    = 15;
  localparam int QW_MAX  = 32767;

  // Harmonic index, weights and the reciprocal used to divide by a weight.
  localparam int J_W        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int KMAX       = 2 * MAX_TERMS - 1;
  localparam int W_W        = $clog2(KMAX * KMAX + 1);
  localparam int FRAC       = 15;
  localparam int MAG_W      = AMP_W + QW_W;
  localparam int NQ_W       = MAG_W - FRAC + 2;
  localparam int NQ_SUM_W   = NQ_W + FRAC;
  localparam int RECIP_SHIFT = NQ_W + W_W;
  localparam int RECIP_W    = RECIP_SHIFT + 1;
  localparam int PROD_W     = NQ_W + RECIP_W;
  localparam int TERM_W     = NQ_W + 1;
  localparam int ACC_W      = TERM_W + J_W + 1;

  localparam int SAMPLE_W   = 16;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Taylor coefficients of sin(pi/2 * x) in Q30.
  localparam longint unsigned COEF1 = 64'd1686629713;
  localparam longint unsigned COEF3 = 64'd693598668;
  localparam longint unsigned COEF5 = 64'd85569306;
  localparam longint unsigned COEF7 = 64'd5026995;
  localparam longint unsigned COEF9 = 64'd172271;

  typedef logic [QW_W-1:0]    qw_tbl_t [0:QLEN];
  typedef logic [W_W-1:0]     w_tbl_t  [0:MAX_TERMS-1];
  typedef logic [RECIP_W-1:0] r_tbl_t  [0:MAX_TERMS-1];

  // One term request handed to the term unit.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [TABLE_BITS-1:0] tbl_idx;
    logic [J_W-1:0]        term_j;
    logic                  tri_wave;
  } atg_issue_t;

  // One finished, signed harmonic term.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [TERM_W-1:0] value;
  } atg_term_t;

  // Quarter-wave entry q, Horner evaluation in Q30 with truncating products.
  function automatic logic [QW_W-1:0] qw_entry(input int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x  = longint'(q) << (30 - (TABLE_BITS - 2));
    x2 = (x * x) >> 30;
    t  = COEF9;
    t  = COEF7 - ((x2 * t) >> 30);
    t  = COEF5 - ((x2 * t) >> 30);
    t  = COEF3 - ((x2 * t) >> 30);
    t  = COEF1 - ((x2 * t) >> 30);
    y  = (x * t) >> 30;
    y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
    if (y > 64'(QW_MAX)) begin
      y = 64'(QW_MAX);
    end
    return QW_W'(y);
  endfunction

  function automatic qw_tbl_t build_qw();
    qw_tbl_t tbl;
    for (int q = 0; q <= QLEN; q++) begin
      tbl[q] = qw_entry(q);
    end
    return tbl;
  endfunction

  // Weight of odd harmonic k = 2j+1: k for square, k squared for triangle.
  function automatic w_tbl_t build_w(input logic tri_wave);
    w_tbl_t tbl;
    int k;
    for (int j = 0; j < MAX_TERMS; j++) begin
      k = 2 * j + 1;
      tbl[j] = tri_wave ? W_W'(k * k) : W_W'(k);
    end
    return tbl;
  endfunction

  // ceil(2^RECIP_SHIFT / w) by shift-and-subtract long division.
  function automatic logic [RECIP_W-1:0] recip_of(input longint unsigned w);
    longint unsigned num;
    longint unsigned rem;
    longint unsigned quo;
    num = (64'd1 << RECIP_SHIFT) + w - 64'd1;
    rem = 64'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      quo = quo << 1;
      if (rem >= w) begin
        rem = rem - w;
        quo = quo | 64'd1;
      end
    end
    return RECIP_W'(quo);
  endfunction

  function automatic r_tbl_t build_r(input logic tri_wave);
    r_tbl_t tbl;
    w_tbl_t wt;
    wt = build_w(tri_wave);
    for (int j = 0; j < MAX_TERMS; j++) begin
      tbl[j] = recip_of(64'(wt[j]));
    end
    return tbl;
  endfunction

  localparam qw_tbl_t QW_TABLE  = build_qw();
  localparam w_tbl_t  SQ_WEIGHT = build_w(1'b0);
  localparam w_tbl_t  TR_WEIGHT = build_w(1'b1);
  localparam r_tbl_t  SQ_RECIP  = build_r(1'b0);
  localparam r_tbl_t  TR_RECIP  = build_r(1'b1);

endpackage

`default_nettype wire

FILE: rtl/atg_if.sv
// Handshake channels of the additive tone generator: tick input and sample output.
// Depends on atg_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface atg_in_if
  import atg_pkg::*;
;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface atg_out_if
  import atg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       saturated;

  modport source (output valid, output sample, output saturated, input ready);
  modport sink   (input valid, input sample, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/additive_tone_generator_unit.sv
// Top level of the additive tone generator: configuration registers, phase
// accumulator, term sequencer, accumulator and output register.
// Depends on atg_pkg, atg_if.sv and atg_term_unit.
//
//   Channel   Direction  Transfer carries
//   in_chan   sink       restart (clear phase before this sample)
//   out_chan  source     sample, saturated
//   APB       slave      phase_step, amplitude, wave_shape, term_count
//
// A tick passes through the issue, drain and finish states before its sample is
// loaded; the issue state hands n harmonic terms (one in sine mode) to the shared
// term unit, which accepts one term per cycle and is pipelined. A new tick is taken
// only after the previous sum has been loaded into the output register.
// Reset clears the phase, the registers and the output valid flag; no sweep follows.
// The next tick is accepted as soon as the sequencer is idle, even while the
// previous sample still waits in the output register; a stalled output holds
// the finished sum until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module additive_tone_generator_unit
  import atg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  atg_in_if.sink                  in_chan,
  atg_out_if.source               out_chan,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

  // Configuration registers.
  logic [STEP_W-1:0]    phase_step_r;
  logic [AMP_W-1:0]     amplitude_r;
  logic [SHAPE_W-1:0]   wave_shape_r;
  logic [COUNT_W-1:0]   term_count_r;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      amplitude_r  <= '0;
      wave_shape_r <= SHAPE_SINE;
      term_count_r <= COUNT_W'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PHASE_STEP: phase_step_r <= pwdata[STEP_W-1:0];
        REG_AMPLITUDE:  amplitude_r  <= pwdata[AMP_W-1:0];
        REG_WAVE_SHAPE: wave_shape_r <= pwdata[SHAPE_W-1:0];
        REG_TERM_COUNT: term_count_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PHASE_STEP: prdata = phase_step_r;
      REG_AMPLITUDE:  prdata = 32'(amplitude_r);
      REG_WAVE_SHAPE: prdata = 32'(wave_shape_r);
      REG_TERM_COUNT: prdata = 32'(term_count_r);
      default:        prdata = '0;
    endcase
  end

  // Sequencer state.
  state_t                    state_r, state_nxt;
  logic [PHASE_BITS-1:0]     phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]     kp_r, kp_nxt;
  logic [PHASE_BITS-1:0]     dph_r, dph_nxt;
  logic [J_W-1:0]            j_r, j_nxt;
  logic [J_W-1:0]            last_j_r, last_j_nxt;
  logic                      tri_r, tri_nxt;
  logic signed [ACC_W-1:0]   sum_r, sum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                      out_sat_r, out_sat_nxt;

  logic                  in_xfer;
  logic                  out_free;
  logic [PHASE_BITS-1:0] start_phase;
  logic                  harmonic_mode;
  logic [J_W-1:0]        count_last;
  atg_issue_t            issue;
  atg_term_t             term;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign start_phase   = in_chan.restart ? '0 : phase_r;
  assign harmonic_mode = (wave_shape_r == SHAPE_SQUARE) || (wave_shape_r == SHAPE_TRIANGLE);

  // Last harmonic index: a count of zero means one term, and the count is
  // capped at the table depth.
  always_comb begin
    if (term_count_r == '0) begin
      count_last = '0;
    end else if (32'(term_count_r) > MAX_TERMS) begin
      count_last = J_W'(MAX_TERMS - 1);
    end else begin
      count_last = J_W'(32'(term_count_r) - 1);
    end
  end

  assign issue.valid    = (state_r == ST_ISSUE);
  assign issue.last     = (j_r == last_j_r);
  assign issue.tbl_idx  = kp_r[PHASE_BITS-1 -: TABLE_BITS];
  assign issue.term_j   = j_r;
  assign issue.tri_wave = tri_r;

  atg_term_unit u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .amplitude (amplitude_r),
    .term      (term)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    kp_nxt         = kp_r;
    dph_nxt        = dph_r;
    j_nxt          = j_r;
    last_j_nxt     = last_j_r;
    tri_nxt        = tri_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;

    if (term.valid) begin
      sum_nxt = sum_r + ACC_W'(term.value);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // Harmonic k reads at k times the phase: start at the phase and step by twice it.
          kp_nxt     = start_phase;
          dph_nxt    = start_phase << 1;
          phase_nxt  = start_phase + PHASE_BITS'(phase_step_r);
          j_nxt      = '0;
          last_j_nxt = harmonic_mode ? count_last : '0;
          tri_nxt    = (wave_shape_r == SHAPE_TRIANGLE);
          sum_nxt    = '0;
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        kp_nxt = kp_r + dph_r;
        j_nxt  = j_r + J_W'(1);
        if (j_r == last_j_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (term.valid && term.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sum_r > SAT_HI) begin
            out_sample_nxt = SAMPLE_W'(SAMPLE_MAX);
            out_sat_nxt    = 1'b1;
          end else if (sum_r < SAT_LO) begin
            out_sample_nxt = SAMPLE_W'(SAMPLE_MIN);
            out_sat_nxt    = 1'b1;
          end else begin
            out_sample_nxt = sum_r[SAMPLE_W-1:0];
            out_sat_nxt    = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kp_r         <= kp_nxt;
    dph_r        <= dph_nxt;
    j_r          <= j_nxt;
    last_j_r     <= last_j_nxt;
    tri_r        <= tri_nxt;
    sum_r        <= sum_nxt;
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.sample    = out_sample_r;
  assign out_chan.saturated = out_sat_r;

`ifndef SYNTH
  // A tick transfer always starts the sequencer at the first harmonic.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_ISSUE) && (j_r == '0))
    else $error("sequencer did not start at the first term");

  // Terms only leave the term unit while a sample is being built.
  a_term_window: assert property (@(posedge clk) disable iff (!rst_n)
    term.valid |-> (state_r == ST_ISSUE) || (state_r == ST_DRAIN))
    else $error("term arrived outside a sample computation");

  // A clipped sample sits at one of the rails.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_sample_r == SAMPLE_W'(SAMPLE_MAX)) || (out_sample_r == SAMPLE_W'(SAMPLE_MIN)))
    else $error("saturated sample not at a rail");

  // The output register is loaded only from the finish state.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("output loaded outside the finish state");
`endif

endmodule

`default_nettype wire

FILE: rtl/atg_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
// Depends on atg_pkg for the table contents and widths.
`timescale 1ns / 1ps
`default_nettype none

module atg_sine_rom
  import atg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [QA_W-1:0] rd_addr,
  output logic      [QW_W-1:0] rd_data_r
);

  localparam qw_tbl_t ROM = QW_TABLE;

  always_ff @(posedge clk) begin
    rd_data_r <= ROM[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/atg_term_unit.sv
// Five-stage harmonic term unit: table lookup, amplitude multiply, rounding and
// division by the harmonic weight through a reciprocal multiply. Uses atg_pkg, atg_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

module atg_term_unit
  import atg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire atg_issue_t       issue,
  input  wire logic [AMP_W-1:0] amplitude,
  output atg_term_t             term
);

  // Stage 0: fold the table index into the quarter wave.
  logic [1:0]      quad;
  logic [QA_W-1:0] r_off;
  logic [QA_W-1:0] rom_addr;
  logic [QW_W-1:0] qw_data;

  assign quad     = issue.tbl_idx[TABLE_BITS-1 -: 2];
  assign r_off    = QA_W'(issue.tbl_idx[TABLE_BITS-3:0]);
  assign rom_addr = quad[0] ? (QA_W'(QLEN) - r_off) : r_off;

  atg_sine_rom u_rom (
    .clk       (clk),
    .rd_addr   (rom_addr),
    .rd_data_r (qw_data)
  );

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               last1_r, last2_r, last3_r, last4_r;
  logic               neg1_r, neg2_r, neg3_r, neg4_r;
  logic [W_W-1:0]     w1_r, w2_r;
  logic [RECIP_W-1:0] m1_r, m2_r, m3_r;
  logic [MAG_W-1:0]   mag2_r;
  logic [NQ_W-1:0]    nq3_r;
  logic [PROD_W-1:0]  prod4_r;

  logic [NQ_SUM_W-1:0] nq_sum;
  logic [NQ_W-1:0]     q4;
  logic [TERM_W-1:0]   q4_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Rounded quotient: (mag + w/2 * 2^15) / (w * 2^15) = ((mag + w * 2^14) >> 15) / w.
  assign nq_sum = NQ_SUM_W'(mag2_r) + (NQ_SUM_W'(w2_r) << (FRAC - 1));

  always_ff @(posedge clk) begin
    last1_r <= issue.last;
    // The negative half of the wave and odd triangle terms each flip the sign.
    neg1_r  <= quad[1] ^ (issue.tri_wave & issue.term_j[0]);
    w1_r    <= issue.tri_wave ? TR_WEIGHT[issue.term_j] : SQ_WEIGHT[issue.term_j];
    m1_r    <= issue.tri_wave ? TR_RECIP[issue.term_j] : SQ_RECIP[issue.term_j];

    last2_r <= last1_r;
    neg2_r  <= neg1_r;
    w2_r    <= w1_r;
    m2_r    <= m1_r;
    mag2_r  <= MAG_W'(amplitude) * MAG_W'(qw_data);

    last3_r <= last2_r;
    neg3_r  <= neg2_r;
    m3_r    <= m2_r;
    nq3_r   <= nq_sum[NQ_SUM_W-1:FRAC];

    last4_r <= last3_r;
    neg4_r  <= neg3_r;
    prod4_r <= PROD_W'(nq3_r) * PROD_W'(m3_r);
  end

  assign q4     = prod4_r[RECIP_SHIFT +: NQ_W];
  assign q4_ext = {1'b0, q4};

  assign term.valid = v4_r;
  assign term.last  = last4_r;
  assign term.value = neg4_r ? -$signed(q4_ext) : $signed(q4_ext);

endmodule

`default_nettype wire

FILE: dv/tb_additive_tone_generator_unit.sv
// Self-checking testbench for additive_tone_generator_unit: drives ticks over the input
// channel, programs the APB registers between phases and checks every sample against a
// local model of the sine, square and triangle synthesis. Depends on atg_pkg and atg_if.sv.
`timescale 1ns / 1ps

module tb_additive_tone_generator_unit;
  import atg_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       saturated;
  } tone_sample_t;

  // Shape code that the block does not define; it must fall back to sine.
  localparam logic [SHAPE_W-1:0] SHAPE_UNUSED = 2'd3;
  // Settle time after draining, with margin over the longest tick, before touching registers.
  localparam int SETTLE_CYCLES = 40;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  atg_in_if  in_if ();
  atg_out_if out_if ();

  additive_tone_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the synthesizer state and registers.
  int                    quarter_wave_q15 [0:QLEN];
  logic [PHASE_BITS-1:0] tone_phase;
  logic [STEP_W-1:0]     tone_step;
  logic [AMP_W-1:0]      tone_amp;
  logic [SHAPE_W-1:0]    tone_shape;
  logic [COUNT_W-1:0]    tone_terms;

  bit           tick_backlog [$];
  tone_sample_t expected_samples [$];

  int idle_pct        = 0;
  int stall_pct       = 0;
  int mismatches      = 0;
  int samples_checked = 0;
  int samples_clipped = 0;
  int settings_used   = 0;

  always #5 clk = ~clk;

  // Quarter-wave point q: odd Taylor series of sin(pi/2 * x) in Q30, Horner form.
  function automatic int quarter_sine(int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned acc;
    longint unsigned y;
    x   = longint'(q) << (30 - (TABLE_BITS - 2));
    x2  = (x * x) >> 30;
    acc = COEF9;
    acc = COEF7 - ((x2 * acc) >> 30);
    acc = COEF5 - ((x2 * acc) >> 30);
    acc = COEF3 - ((x2 * acc) >> 30);
    acc = COEF1 - ((x2 * acc) >> 30);
    y   = (x * acc) >> 30;
    y   = (y * 64'd32767 + (64'd1 << 29)) >> 30;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return int'(y);
  endfunction

  function automatic int sine_at(logic [TABLE_BITS-1:0] idx);
    int r;
    r = int'(idx[TABLE_BITS-3:0]);
    case (idx[TABLE_BITS-1:TABLE_BITS-2])
      2'd0:    return quarter_wave_q15[r];
      2'd1:    return quarter_wave_q15[QLEN - r];
      2'd2:    return -quarter_wave_q15[r];
      default: return -quarter_wave_q15[QLEN - r];
    endcase
  endfunction

  // One harmonic: amplitude * sin(k * phase) / (weight * 32768), rounded half away from zero.
  function automatic int harmonic_term(int unsigned k, int unsigned weight,
                                       logic [PHASE_BITS-1:0] ph);
    logic [PHASE_BITS-1:0] kp;
    longint                prod;
    longint                den;
    longint                mag;
    longint                quo;
    kp   = PHASE_BITS'(k * ph);
    prod = longint'(tone_amp) * longint'(sine_at(kp[PHASE_BITS-1 -: TABLE_BITS]));
    den  = longint'(weight) * 64'sd32768;
    mag  = (prod < 0) ? -prod : prod;
    quo  = (mag + den / 2) / den;
    return (prod < 0) ? -int'(quo) : int'(quo);
  endfunction

  function automatic tone_sample_t synth_tick(logic restart);
    tone_sample_t res;
    int           sum;
    int           n;
    int           term;
    int unsigned  k;
    sum = 0;
    if (restart) begin
      tone_phase = '0;
    end
    if (tone_shape == SHAPE_SQUARE || tone_shape == SHAPE_TRIANGLE) begin
      n = (tone_terms == 0) ? 1 : ((tone_terms > MAX_TERMS) ? MAX_TERMS : int'(tone_terms));
      for (int j = 0; j < n; j++) begin
        k = 2 * j + 1;
        if (tone_shape == SHAPE_SQUARE) begin
          sum += harmonic_term(k, k, tone_phase);
        end else begin
          term = harmonic_term(k, k * k, tone_phase);
          sum += (j % 2 == 1) ? -term : term;
        end
      end
    end else begin
      sum = harmonic_term(1, 1, tone_phase);
    end
    res.saturated = 1'b0;
    if (sum > SAMPLE_MAX) begin
      sum           = SAMPLE_MAX;
      res.saturated = 1'b1;
    end else if (sum < SAMPLE_MIN) begin
      sum           = SAMPLE_MIN;
      res.saturated = 1'b1;
    end
    res.sample = SAMPLE_W'(sum);
    tone_phase = tone_phase + tone_step;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] sample %0d: %s is %0d, expected %0d", $time, samples_checked, what, got,
             want);
    mismatches++;
  endtask

  // Tick driver: a new transfer is offered once the previous one has gone through.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (tick_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.restart <= tick_backlog.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Checks outgoing samples first, then queues the expectation for an accepted tick.
  always @(posedge clk) begin
    tone_sample_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", int'(out_if.sample), 0);
        end else begin
          want = expected_samples.pop_front();
          if (out_if.sample !== want.sample) begin
            report_mismatch("sample", int'(out_if.sample), int'(want.sample));
          end
          if (out_if.saturated !== want.saturated) begin
            report_mismatch("saturated", int'(out_if.saturated), int'(want.saturated));
          end
          if (want.saturated) begin
            samples_clipped++;
          end
          samples_checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_samples.push_back(synth_tick(in_if.restart));
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PHASE_STEP: tone_step  = value[STEP_W-1:0];
      REG_AMPLITUDE:  tone_amp   = value[AMP_W-1:0];
      REG_WAVE_SHAPE: tone_shape = value[SHAPE_W-1:0];
      REG_TERM_COUNT: tone_terms = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [31:0] step, int amp, logic [SHAPE_W-1:0] shape,
                               int terms);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_AMPLITUDE, 32'(amp));
    write_reg(REG_WAVE_SHAPE, 32'(shape));
    write_reg(REG_TERM_COUNT, 32'(terms));
    settings_used++;
  endtask

  // Returns once every queued tick has gone out and its sample has been checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || in_if.valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_ticks(int count);
    for (int i = 0; i < count; i++) begin
      tick_backlog.push_back($urandom_range(9) == 0);
    end
  endtask

  task automatic random_setting();
    logic [31:0]        step;
    int                 amp;
    logic [SHAPE_W-1:0] shape;
    int                 terms;
    int                 pick;
    case ($urandom_range(3))
      0: step = $urandom_range(32'h00FF_FFFF);
      1: begin
        pick = $urandom_range(3);
        step = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
               (pick == 2) ? 32'h8000_0000 : 32'h1;
      end
      default: step = $urandom;
    endcase
    case ($urandom_range(4))
      0: amp = 32767;
      1: amp = 0;
      default: amp = $urandom_range(32767);
    endcase
    pick = $urandom_range(9);
    shape = (pick < 4) ? SHAPE_SQUARE : (pick < 8) ? SHAPE_TRIANGLE :
            (pick == 8) ? SHAPE_SINE : SHAPE_UNUSED;
    terms = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
    apply_setting(step, amp, shape, terms);
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    for (int q = 0; q <= QLEN; q++) begin
      quarter_wave_q15[q] = quarter_sine(q);
    end
    tone_phase = '0;
    tone_step  = '0;
    tone_amp   = '0;
    tone_shape = SHAPE_SINE;
    tone_terms = COUNT_W'(1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: silent sine.
    @(negedge clk);
    tick_backlog = '{1'b0, 1'b0};
    wait_drained();
    // Full-scale sine at the four quadrant points.
    apply_setting(32'h4000_0000, 32767, SHAPE_SINE, 1);
    tick_backlog = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_drained();
    // Undefined shape code behaves as sine and ignores the term count.
    apply_setting(32'h2000_0000, 32767, SHAPE_UNUSED, 5);
    tick_backlog = '{1'b1, 1'b0, 1'b0};
    wait_drained();
    // A term count of zero still sums one harmonic.
    apply_setting(32'h1000_0000, 32767, SHAPE_SQUARE, 0);
    tick_backlog = '{1'b1, 1'b0, 1'b0};
    wait_drained();
    // Triangle peaks exceed full scale and clip on both sides.
    apply_setting(32'h4000_0000, 32767, SHAPE_TRIANGLE, 16);
    tick_backlog = '{1'b1, 1'b0, 1'b0, 1'b0};
    wait_drained();
    // Oversized term count is limited to the maximum; the largest step wraps the phase.
    apply_setting(32'hFFFF_FFFF, 20000, SHAPE_SQUARE, 31);
    tick_backlog = '{1'b0, 1'b0, 1'b1};
    wait_drained();
    apply_setting(32'h0000_0001, 1, SHAPE_SINE, 17);
    tick_backlog = '{1'b0, 1'b0};
    wait_drained();

    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      random_setting();
      @(negedge clk);
      push_ticks(25);
      // The sender holds back here until every sample of the first half is in.
      wait_drained();
      push_ticks(25);
      wait_drained();
    end

    $display("Checked %0d samples (%0d clipped) over %0d register settings.",
             samples_checked, samples_clipped, settings_used);
    $display("Ticks ran with no idling, a slow sender, a slow receiver and both mixed.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d samples still expected.", expected_samples.size());
    $display("FAILURE");
    $finish;
  end

endmodule
